// ----- design/dsp2_pkg.sv -----
// Package for the double scale-by-power-of-two unit.
// Holds binary64 field constants and the leading-zero count helper; no dependencies.
`default_nettype none
package dsp2_pkg;
    localparam int FRAC_W = 52;
    localparam int EXP_W  = 11;
    localparam logic [EXP_W-1:0] EXP_MAX = 11'h7FF;
    // Wide signed exponent, enough for 11-bit field plus 16-bit scale.
    localparam int NE_W = 18;

    // Leading-zero count of a 53-bit significand (input nonzero).
    function automatic logic [5:0] lzc53(input logic [52:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd0;
        hit = 1'b0;
        for (int i = 52; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                hit = 1'b1;
                n   = 6'(52 - i);
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ----- design/double_scale_by_power_of_two_unit.sv -----
// Top level of the double scale-by-power-of-two unit (ldexp on binary64).
// Depends on dsp2_pkg.
//
// One item may be started every clock cycle; busy is always low. Each result
// appears on result_bits with done high once it has passed the four register
// stages: normalize, exponent add, right shift, round.
// The receiver cannot stall, so results are shown once and not held.
`default_nettype none
module double_scale_by_power_of_two_unit
    import dsp2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] x_bits,
    input  wire logic signed [15:0] scale_exp,
    output logic             done,
    output logic [63:0]      result_bits
);
    // Stage 1: classify and normalize.
    logic              v1_reg;
    logic              pass1_reg;
    logic [63:0]       x1_reg;
    logic [52:0]       sig1_reg;
    logic signed [NE_W-1:0] ex1_reg;
    logic signed [15:0] k1_reg;

    logic [10:0] ex_in;
    logic [51:0] fr_in;
    logic [5:0]  lz;
    assign ex_in = x_bits[62:52];
    assign fr_in = x_bits[51:0];
    assign lz    = lzc53({1'b0, fr_in});
    assign busy  = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x_bits;
        k1_reg    <= scale_exp;
        pass1_reg <= (ex_in == EXP_MAX) || (ex_in == '0 && fr_in == '0);
        if (ex_in == '0)
        begin
            // Subnormal: shift the leading one into the hidden position.
            sig1_reg <= {1'b0, fr_in} << lz;
            ex1_reg  <= NE_W'(1) - NE_W'(lz);
        end
        else
        begin
            sig1_reg <= {1'b1, fr_in};
            ex1_reg  <= NE_W'(ex_in);
        end
    end

    // Stage 2: add the scale to the exponent.
    logic              v2_reg;
    logic [63:0]       x2_reg;
    logic [52:0]       sig2_reg;
    logic signed [NE_W-1:0] ne2_reg;
    logic              pass2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        x2_reg    <= x1_reg;
        sig2_reg  <= sig1_reg;
        pass2_reg <= pass1_reg;
        ne2_reg   <= ex1_reg + NE_W'(k1_reg);
    end

    // Stage 3: decide the result class and do the denormalizing shift, with remainder kept for rounding.
    logic        v3_reg;
    logic [63:0] x3_reg;
    logic [1:0]  cls3_reg;   // 0 pass, 1 inf, 2 normal, 3 denormal
    logic [10:0] ne3_reg;
    logic [52:0] sig3_reg;
    logic [52:0] q3_reg;
    logic        rnd3_reg;
    logic        stk3_reg;

    logic [5:0]   sh;
    logic [106:0] wide;
    assign sh   = (ne2_reg < -NE_W'(53)) ? 6'd55 : 6'(NE_W'(1) - ne2_reg);
    assign wide = {sig2_reg, 54'd0} >> sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        x3_reg   <= x2_reg;
        sig3_reg <= sig2_reg;
        ne3_reg  <= ne2_reg[10:0];
        q3_reg   <= wide[106:54];
        rnd3_reg <= wide[53];
        stk3_reg <= |wide[52:0];
        if (pass2_reg)
            cls3_reg <= 2'd0;
        else if (ne2_reg >= $signed(NE_W'(EXP_MAX)))
            cls3_reg <= 2'd1;
        else if (ne2_reg >= NE_W'(1))
            cls3_reg <= 2'd2;
        else
            cls3_reg <= 2'd3;
    end

    // Stage 4: round to nearest even and assemble.
    logic        v4_reg;
    logic [63:0] res4_reg;
    logic [52:0] qr;
    assign qr = q3_reg + 53'(rnd3_reg && (stk3_reg || q3_reg[0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (cls3_reg)
            2'd0: res4_reg <= x3_reg;
            2'd1: res4_reg <= {x3_reg[63], EXP_MAX, 52'd0};
            2'd2: res4_reg <= {x3_reg[63], ne3_reg, sig3_reg[51:0]};
            default: res4_reg <= {x3_reg[63], 10'd0, qr};
        endcase
    end

    assign done        = v4_reg;
    assign result_bits = res4_reg;
endmodule
`default_nettype wire

// ----- design/dsp2_checker.sv -----
// Port-level checker for the double scale-by-power-of-two unit, with its bind.
// Depends on dsp2_pkg and the top level.
`default_nettype none
module dsp2_checker
    import dsp2_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [63:0] x_bits,
    input wire logic        done,
    input wire logic [63:0] result_bits
);
    // A started item yields a result with done high.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done) else $error("result missing");
    // No result without a matching earlier start.
    a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4)) else $error("spurious result");
    // NaN and infinity operands come back unchanged.
    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        start && x_bits[62:52] == EXP_MAX |-> ##4 result_bits == $past(x_bits, 4))
        else $error("special operand altered");
    // The unit never stalls the requester.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule

bind double_scale_by_power_of_two_unit dsp2_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .x_bits(x_bits),
    .done(done), .result_bits(result_bits)
);
`default_nettype wire
